// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the matrix inverse top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside reset
`define MI3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define MI3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mi3_pkg.sv -----
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and types of the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int NUM_ELEM      = 9;
  localparam int THR_W         = 31;
  localparam int PROD_W        = 64;
  localparam int COF_W         = 65;
  localparam int MAG_W         = 64;
  localparam int TERM_W        = 97;
  localparam int DET_W         = 99;
  localparam int DIV_W         = 96;
  localparam int Q_W           = 32;
  localparam int FRONT_ST      = 6;
  localparam int LANE_ST       = Q_W + 1;
  localparam int NUM_ST        = FRONT_ST + LANE_ST + 1;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [DIV_W-1:0] dvs;
    logic             sing;
  } lane_in_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           neg;
    logic           sing;
  } lane_out_t;

endpackage

// ----- hdl/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 Q-format matrix inverse by adjugate over determinant, fully pipelined.
// ----------------------------------------------------------------------------
// channel   dir  signals                 content
// in        in   in_tvalid/tready/tdata  r1c1..r3c3, 32 bits each
// out       out  out_tvalid/tready/tdata inverse r1c1..r3c3, 32 bits each
//                out_tuser               [0] is_singular, [1] saturated
// cfg       in   cfg_wr_en/cfg_wr_data   singular threshold, 31 bits
//
// One word per cycle unless the output stalls. 6 front stages (products,
// cofactors, determinant), 33 divider stages per lane (one load stage, then
// one quotient bit per stage), 1 output stage. Each stage holds while the
// one after it is full and stalled; empty stages fill. Reset empties the
// pipeline and sets the threshold to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix3_inverse #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3
  input  logic [mi3_pkg::NUM_ELEM*mi3_pkg::ELEM_W-1:0] in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, ..., inv_r3c3
  output logic [mi3_pkg::NUM_ELEM*mi3_pkg::ELEM_W-1:0] out_tdata,
  // is_singular, saturated
  output logic [1:0]                                   out_tuser,
  input  logic                                         cfg_wr_en,
  input  logic [mi3_pkg::THR_W-1:0]                    cfg_wr_data
);

  localparam int NS = mi3_pkg::NUM_ST;
  localparam int FS = mi3_pkg::FRONT_ST;
  localparam int LS = mi3_pkg::LANE_ST;

  logic [mi3_pkg::THR_W-1:0] thr_r;
  logic [NS-1:0]             v_r;
  logic [NS-1:0]             v_nxt;
  logic [NS-1:0]             en;
  logic                      sing_r;
  logic                      sat_r;

  mi3_pkg::lane_in_t  lane_in  [mi3_pkg::NUM_ELEM];
  mi3_pkg::lane_out_t lane_out [mi3_pkg::NUM_ELEM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mi3_pkg::THR_W'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .en      (en[FS-1:0]),
    .mat     (in_tdata),
    .thr     (thr_r),
    .lane_in (lane_in)
  );

  for (genvar k = 0; k < mi3_pkg::NUM_ELEM; k++) begin : g_lane
    mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en   (en[FS+LS-1:FS]),
      .din  (lane_in[k]),
      .dout (lane_out[k])
    );
  end

  mi3_merge u_merge (
    .clk      (clk),
    .en       (en[NS-1]),
    .lane_out (lane_out),
    .data_r   (out_tdata),
    .sing_r   (sing_r),
    .sat_r    (sat_r)
  );

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];
  assign out_tuser  = {sat_r, sing_r};

  `MI3_ASSERT(a_sing_zero, out_tvalid && out_tuser[0] |-> (out_tdata == '0) && !out_tuser[1], "singular word not zero")
  `MI3_ASSERT(a_accept_fill, in_tvalid && in_tready |=> v_r[0], "accepted word lost at entry")
  `MI3_ASSERT(a_hold_full, v_r[NS-1] && !out_tready |=> v_r[NS-1] && $stable(out_tdata), "output word not held")
  `MI3_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "pipeline not empty after reset")

endmodule

// ----- hdl/mi3_front.sv -----
// ----------------------------------------------------------------------------
// mi3_front
// Products, cofactors, determinant and singularity test, six stages.
// ----------------------------------------------------------------------------
module mi3_front #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic [mi3_pkg::FRONT_ST-1:0]            en,
  input  logic [mi3_pkg::NUM_ELEM*mi3_pkg::ELEM_W-1:0] mat,
  input  logic [mi3_pkg::THR_W-1:0]               thr,
  output mi3_pkg::lane_in_t                       lane_in [mi3_pkg::NUM_ELEM]
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam int PW = mi3_pkg::PROD_W;
  localparam int CW = mi3_pkg::COF_W;
  localparam int TW = mi3_pkg::TERM_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int NE = mi3_pkg::NUM_ELEM;

  logic signed [EW-1:0] a [3][3];
  logic signed [PW-1:0] p1_r [NE];
  logic signed [PW-1:0] p2_r [NE];
  logic signed [EW-1:0] a0_r [2][3];
  logic signed [CW-1:0] cof2_r [NE];
  logic signed [CW-1:0] cof3_r [NE];
  logic signed [CW-1:0] cof4_r [NE];
  logic signed [CW-1:0] cof5_r [NE];
  logic signed [CW:0]   ph_r [3];
  logic signed [CW:0]   pl_r [3];
  logic signed [TW-1:0] term_r [3];
  logic signed [DW-1:0] det_r;
  logic [DW-1:0]        adet;
  logic [DW-1:0]        lim;
  logic                 sing;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a[r][c] = $signed(mat[(r*3+c)*EW +: EW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1_r[r*3+c] <= a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3];
          p2_r[r*3+c] <= a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
        end
      end
      for (int c = 0; c < 3; c++) a0_r[0][c] <= a[0][c];
    end
    if (en[1]) begin
      for (int i = 0; i < NE; i++) begin
        cof2_r[i] <= CW'(p1_r[i]) - CW'(p2_r[i]);
      end
      a0_r[1] <= a0_r[0];
    end
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        ph_r[c] <= a0_r[1][c] * $signed(cof2_r[c][CW-1:32]);
        pl_r[c] <= a0_r[1][c] * $signed({1'b0, cof2_r[c][31:0]});
      end
      cof3_r <= cof2_r;
    end
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        term_r[c] <= (TW'(ph_r[c]) <<< 32) + TW'(pl_r[c]);
      end
      cof4_r <= cof3_r;
    end
    if (en[4]) begin
      det_r  <= DW'(term_r[0]) + DW'(term_r[1]) + DW'(term_r[2]);
      cof5_r <= cof4_r;
    end
  end

  always_comb begin
    adet = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    lim  = DW'({thr, {(2*FRAC_BITS){1'b0}}});
    sing = (adet == '0) || (adet < lim);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          lane_in[r*3+c].mag  <= cof5_r[c*3+r][CW-1] ?
                                 mi3_pkg::MAG_W'(-cof5_r[c*3+r]) :
                                 mi3_pkg::MAG_W'(cof5_r[c*3+r]);
          lane_in[r*3+c].neg  <= cof5_r[c*3+r][CW-1] ^ det_r[DW-1];
          lane_in[r*3+c].dvs  <= adet[mi3_pkg::DIV_W-1:0];
          lane_in[r*3+c].sing <= sing;
        end
      end
    end
  end

endmodule

// ----- hdl/mi3_div_lane.sv -----
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider, one quotient bit per stage after a load stage, with overflow test.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [mi3_pkg::LANE_ST-1:0] en,
  input  mi3_pkg::lane_in_t           din,
  output mi3_pkg::lane_out_t          dout
);

  localparam int QW = mi3_pkg::Q_W;
  localparam int DV = mi3_pkg::DIV_W;
  localparam int NW = mi3_pkg::MAG_W + 2 * FRAC_BITS;

  logic [NW-1:0] num;
  logic [DV-1:0] rem_r [mi3_pkg::LANE_ST];
  logic [QW-1:0] q_r   [mi3_pkg::LANE_ST];
  logic [QW-1:0] lo_r  [mi3_pkg::LANE_ST];
  logic [DV-1:0] d_r   [mi3_pkg::LANE_ST];
  logic          ovf_r [mi3_pkg::LANE_ST];
  logic          neg_r [mi3_pkg::LANE_ST];
  logic          sing_r[mi3_pkg::LANE_ST];

  assign num = {din.mag, {(2*FRAC_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= DV'(num[NW-1:QW]);
      ovf_r[0]  <= DV'(num[NW-1:QW]) >= din.dvs;
      lo_r[0]   <= num[QW-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= din.dvs;
      neg_r[0]  <= din.neg;
      sing_r[0] <= din.sing;
    end
  end

  for (genvar j = 1; j < mi3_pkg::LANE_ST; j++) begin : g_step
    logic [DV:0] rem_t;
    logic        ge;

    always_comb begin
      rem_t = {rem_r[j-1], lo_r[j-1][QW-1]};
      ge    = rem_t >= {1'b0, d_r[j-1]};
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j]  <= ge ? DV'(rem_t - {1'b0, d_r[j-1]}) : DV'(rem_t);
        q_r[j]    <= {q_r[j-1][QW-2:0], ge};
        lo_r[j]   <= {lo_r[j-1][QW-2:0], 1'b0};
        d_r[j]    <= d_r[j-1];
        ovf_r[j]  <= ovf_r[j-1];
        neg_r[j]  <= neg_r[j-1];
        sing_r[j] <= sing_r[j-1];
      end
    end
  end

  assign dout.q    = q_r[mi3_pkg::LANE_ST-1];
  assign dout.ovf  = ovf_r[mi3_pkg::LANE_ST-1];
  assign dout.neg  = neg_r[mi3_pkg::LANE_ST-1];
  assign dout.sing = sing_r[mi3_pkg::LANE_ST-1];

endmodule

// ----- hdl/mi3_merge.sv -----
// ----------------------------------------------------------------------------
// mi3_merge
// Saturate and sign the lane quotients, zero a singular word, combine the flags, output register.
// ----------------------------------------------------------------------------
module mi3_merge (
  input  logic                                         clk,
  input  logic                                         en,
  input  mi3_pkg::lane_out_t                           lane_out [mi3_pkg::NUM_ELEM],
  output logic [mi3_pkg::NUM_ELEM*mi3_pkg::ELEM_W-1:0] data_r,
  output logic                                         sing_r,
  output logic                                         sat_r
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam logic [EW-1:0] POS_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] NEG_MAG = {1'b1, {(EW-1){1'b0}}};

  logic [mi3_pkg::NUM_ELEM*EW-1:0] data_nxt;
  logic [mi3_pkg::NUM_ELEM-1:0]    clip;

  always_comb begin
    logic [EW-1:0] lim;
    logic [EW-1:0] v;
    for (int i = 0; i < mi3_pkg::NUM_ELEM; i++) begin
      lim     = lane_out[i].neg ? NEG_MAG : POS_MAX;
      clip[i] = lane_out[i].ovf || (lane_out[i].q > lim);
      v       = clip[i] ? lim : lane_out[i].q;
      data_nxt[i*EW +: EW] = lane_out[0].sing ? '0 : (lane_out[i].neg ? -v : v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      sing_r <= lane_out[0].sing;
      sat_r  <= !lane_out[0].sing && (|clip);
    end
  end

endmodule
